### src/page_translation_table_macros.svh
// Assertion macros shared by the page translation table RTL
`ifndef PAGE_TRANSLATION_TABLE_MACROS_SVH
`define PAGE_TRANSLATION_TABLE_MACROS_SVH

// same-cycle implication, disabled during reset
`define PTT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define PTT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/ptt_pkg.sv
// Shared types and constants for the page translation table
package ptt_pkg;

  localparam int DEF_ENTRIES   = 64;
  localparam int DEF_PAGE_BITS = 12;
  localparam int ADDR_W        = 64;
  localparam int FLAG_W        = 32;
  localparam int CMD_W         = 3;
  localparam int STATUS_W      = 2;
  localparam int LIVE_W        = 7;
  localparam int LIVE_MAX      = 127;

  typedef enum logic [CMD_W-1:0] {
    CMD_MAP         = 3'd0,
    CMD_UNMAP_RANGE = 3'd1,
    CMD_UNMAP_PAGE  = 3'd2,
    CMD_QUERY       = 3'd3,
    CMD_PROTECT     = 3'd4,
    CMD_CLEAR_FLAGS = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_NO_SPACE  = 2'd2
  } outcome_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } state_t;

  // sequencer to compare unit
  typedef struct packed {
    logic load;   // latch a new command, clear accumulators
    logic step;   // one entry passes the compare unit
  } ctl_t;

  // compare unit to output register
  typedef struct packed {
    outcome_t            status;
    logic [ADDR_W-1:0]   phys_out;
    logic [FLAG_W-1:0]   flags_out;
    logic [LIVE_W-1:0]   live_count;
  } res_t;

endpackage

### src/ptt_cell.sv
// One table slot of the rotating entry ring
module ptt_cell
  import ptt_pkg::*;
#(
  parameter int TAG_W = ADDR_W - DEF_PAGE_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              shift,
  input  logic              d_valid,
  input  logic [TAG_W-1:0]  d_tag,
  input  logic [TAG_W-1:0]  d_phys,
  input  logic [FLAG_W-1:0] d_flags,
  output logic              q_valid,
  output logic [TAG_W-1:0]  q_tag,
  output logic [TAG_W-1:0]  q_phys,
  output logic [FLAG_W-1:0] q_flags
);

  logic              valid;
  logic [TAG_W-1:0]  tag;
  logic [TAG_W-1:0]  phys;
  logic [FLAG_W-1:0] flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      tag   <= d_tag;
      phys  <= d_phys;
      flags <= d_flags;
    end
  end

  assign q_valid = valid;
  assign q_tag   = tag;
  assign q_phys  = phys;
  assign q_flags = flags;

endmodule

### src/ptt_head.sv
// Compare and update unit at the head of the ring, with live count
module ptt_head
  import ptt_pkg::*;
#(
  parameter int ENTRIES   = DEF_ENTRIES,
  parameter int PAGE_BITS = DEF_PAGE_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ctl_t                           ctl,
  input  logic [CMD_W-1:0]               command,
  input  logic [ADDR_W-1:0]              address,
  input  logic [ADDR_W-1:0]              end_address,
  input  logic [ADDR_W-1:0]              phys_address,
  input  logic [FLAG_W-1:0]              flag_bits,
  input  logic                           e_valid,
  input  logic [ADDR_W-PAGE_BITS-1:0]    e_tag,
  input  logic [ADDR_W-PAGE_BITS-1:0]    e_phys,
  input  logic [FLAG_W-1:0]              e_flags,
  output logic                           o_valid,
  output logic [ADDR_W-PAGE_BITS-1:0]    o_tag,
  output logic [ADDR_W-PAGE_BITS-1:0]    o_phys,
  output logic [FLAG_W-1:0]              o_flags,
  output res_t                           res
);

  localparam int TAG_W   = ADDR_W - PAGE_BITS;
  localparam int COUNT_W = $clog2(ENTRIES + 1);

  cmd_t              cmd_q;
  logic [TAG_W-1:0]  tag_q;
  logic [PAGE_BITS-1:0] off_q;
  logic [TAG_W:0]    end_tag_q;
  logic [TAG_W-1:0]  pp_q;
  logic [FLAG_W-1:0] flg_q;

  logic              hit, hit_next;
  logic              ins, ins_next;
  logic [TAG_W-1:0]  qphys, qphys_next;
  logic [FLAG_W-1:0] qflags, qflags_next;
  logic [COUNT_W-1:0] count, count_next;

  logic [ADDR_W:0]   end_round;
  logic              match;
  logic              in_rng;

  // end page rounded up: page_addr < end  <=>  tag < ceil(end / page)
  assign end_round = {1'b0, end_address} + {{(TAG_W + 1){1'b0}}, {PAGE_BITS{1'b1}}};

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q     <= cmd_t'(command);
      tag_q     <= address[ADDR_W-1:PAGE_BITS];
      off_q     <= address[PAGE_BITS-1:0];
      end_tag_q <= end_round[ADDR_W:PAGE_BITS];
      pp_q      <= phys_address[ADDR_W-1:PAGE_BITS];
      flg_q     <= flag_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit   <= 1'b0;
      ins   <= 1'b0;
      count <= '0;
    end else begin
      hit   <= hit_next;
      ins   <= ins_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    qphys  <= qphys_next;
    qflags <= qflags_next;
  end

  assign match  = e_valid && (e_tag == tag_q);
  assign in_rng = e_valid && (e_tag >= tag_q) && ({1'b0, e_tag} < end_tag_q);

  always_comb begin
    o_valid     = e_valid;
    o_tag       = e_tag;
    o_phys      = e_phys;
    o_flags     = e_flags;
    hit_next    = hit;
    ins_next    = ins;
    qphys_next  = qphys;
    qflags_next = qflags;
    count_next  = count;
    if (ctl.load) begin
      hit_next    = 1'b0;
      ins_next    = 1'b0;
      qphys_next  = '0;
      qflags_next = '0;
    end else if (ctl.step) begin
      unique case (cmd_q)
        CMD_MAP: begin
          // a free slot seen before the match is filled at once; the
          // stale match met later is dropped, so one copy survives
          if (match) begin
            hit_next = 1'b1;
            if (ins) begin
              o_valid    = 1'b0;
              count_next = count - COUNT_W'(1);
            end else begin
              o_phys  = pp_q;
              o_flags = flg_q;
            end
          end else if (!e_valid && !hit && !ins) begin
            ins_next   = 1'b1;
            o_valid    = 1'b1;
            o_tag      = tag_q;
            o_phys     = pp_q;
            o_flags    = flg_q;
            count_next = count + COUNT_W'(1);
          end
        end
        CMD_UNMAP_RANGE: begin
          if (in_rng) begin
            o_valid    = 1'b0;
            count_next = count - COUNT_W'(1);
          end
        end
        CMD_UNMAP_PAGE: begin
          if (match) begin
            hit_next   = 1'b1;
            o_valid    = 1'b0;
            count_next = count - COUNT_W'(1);
          end
        end
        CMD_QUERY: begin
          if (match) begin
            hit_next    = 1'b1;
            qphys_next  = e_phys;
            qflags_next = e_flags;
          end
        end
        CMD_PROTECT: begin
          if (in_rng) begin
            o_flags = flg_q;
          end
        end
        CMD_CLEAR_FLAGS: begin
          if (match) begin
            hit_next = 1'b1;
            o_flags  = e_flags & ~flg_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res.phys_out  = '0;
    res.flags_out = '0;
    unique case (cmd_q) inside
      CMD_MAP: begin
        res.status = (hit || ins) ? ST_OK : ST_NO_SPACE;
      end
      CMD_UNMAP_PAGE, CMD_QUERY, CMD_CLEAR_FLAGS: begin
        res.status = hit ? ST_OK : ST_NOT_FOUND;
      end
      default: begin
        res.status = ST_OK;
      end
    endcase
    if (cmd_q == CMD_QUERY && hit) begin
      res.phys_out  = {qphys, off_q};
      res.flags_out = qflags;
    end
    res.live_count = (int'(count) > LIVE_MAX) ? LIVE_W'(LIVE_MAX) : LIVE_W'(count);
  end

endmodule

### src/page_translation_table.sv
// Page translation table: ring of slot cells, compare unit and command sequencer
//
// Input channel (in_valid / in_stall) carries one command beat: map, unmap range,
// unmap page, query, protect range or clear flags, with address, end_address,
// phys_address and flag_bits. Output channel (out_valid / out_stall) returns one
// beat per command: status, phys_out, flags_out and live_count.
// The slots sit in a ring of ENTRIES cells that rotates one position per cycle
// while a command scans, past a single compare/update unit, so a command sees
// every slot in exactly one full turn. One command is in flight at a time: a
// new command is accepted only once the last has left the response state.
// in_stall is high from accept until the result beat is loaded into the output
// register; a new command can be accepted while that beat still waits.
// If the receiver stalls, the result beat holds and the finished command waits
// in the response state until the output register frees up.
// Synchronous reset empties the table (all slots invalid, live count zero) and
// drops any beat in flight; tag, page and flag storage is not cleared.
module page_translation_table
  import ptt_pkg::*;
#(
  parameter int ENTRIES   = DEF_ENTRIES,
  parameter int PAGE_BITS = DEF_PAGE_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CMD_W-1:0]    command,
  input  logic [ADDR_W-1:0]   address,
  input  logic [ADDR_W-1:0]   end_address,
  input  logic [ADDR_W-1:0]   phys_address,
  input  logic [FLAG_W-1:0]   flag_bits,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] status,
  output logic [ADDR_W-1:0]   phys_out,
  output logic [FLAG_W-1:0]   flags_out,
  output logic [LIVE_W-1:0]   live_count
);

  `include "page_translation_table_macros.svh"

  localparam int TAG_W  = ADDR_W - PAGE_BITS;
  localparam int SCAN_W = $clog2(ENTRIES);
  localparam int FULL_SHOWN = (ENTRIES > LIVE_MAX) ? LIVE_MAX : ENTRIES;

  state_t state, state_next;
  logic [SCAN_W-1:0] scan_cnt;
  logic scan_last;
  logic out_load;
  ctl_t ctl;
  res_t res;

  logic              c_valid [ENTRIES];
  logic [TAG_W-1:0]  c_tag   [ENTRIES];
  logic [TAG_W-1:0]  c_phys  [ENTRIES];
  logic [FLAG_W-1:0] c_flags [ENTRIES];

  logic              h_valid;
  logic [TAG_W-1:0]  h_tag;
  logic [TAG_W-1:0]  h_phys;
  logic [FLAG_W-1:0] h_flags;

  assign scan_last = (scan_cnt == SCAN_W'(ENTRIES - 1));

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt <= '0;
    end else if (ctl.load) begin
      scan_cnt <= '0;
    end else if (ctl.step) begin
      scan_cnt <= scan_cnt + SCAN_W'(1);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_SCAN;
      S_SCAN: if (scan_last) state_next = S_RESP;
      S_RESP: if (!out_valid || !out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != S_IDLE);
    ctl.load = (state == S_IDLE) && in_valid;
    ctl.step = (state == S_SCAN);
    out_load = (state == S_RESP) && (!out_valid || !out_stall);
  end

  // slot ring: cell i takes from cell i+1, the last cell from the head unit
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic              d_valid;
    logic [TAG_W-1:0]  d_tag;
    logic [TAG_W-1:0]  d_phys;
    logic [FLAG_W-1:0] d_flags;

    if (i == ENTRIES - 1) begin : g_tail
      assign d_valid = h_valid;
      assign d_tag   = h_tag;
      assign d_phys  = h_phys;
      assign d_flags = h_flags;
    end else begin : g_mid
      assign d_valid = c_valid[i+1];
      assign d_tag   = c_tag[i+1];
      assign d_phys  = c_phys[i+1];
      assign d_flags = c_flags[i+1];
    end

    ptt_cell #(
      .TAG_W (TAG_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .shift   (ctl.step),
      .d_valid (d_valid),
      .d_tag   (d_tag),
      .d_phys  (d_phys),
      .d_flags (d_flags),
      .q_valid (c_valid[i]),
      .q_tag   (c_tag[i]),
      .q_phys  (c_phys[i]),
      .q_flags (c_flags[i])
    );
  end

  ptt_head #(
    .ENTRIES   (ENTRIES),
    .PAGE_BITS (PAGE_BITS)
  ) u_head (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .command      (command),
    .address      (address),
    .end_address  (end_address),
    .phys_address (phys_address),
    .flag_bits    (flag_bits),
    .e_valid      (c_valid[0]),
    .e_tag        (c_tag[0]),
    .e_phys       (c_phys[0]),
    .e_flags      (c_flags[0]),
    .o_valid      (h_valid),
    .o_tag        (h_tag),
    .o_phys       (h_phys),
    .o_flags      (h_flags),
    .res          (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status     <= res.status;
      phys_out   <= res.phys_out;
      flags_out  <= res.flags_out;
      live_count <= res.live_count;
    end
  end

  `PTT_ASSERT_NXT(a_accept_starts_scan, ctl.load, state == S_SCAN,
    "accepted command did not start a scan")
  `PTT_ASSERT_IMP(a_beat_after_scan, $rose(out_valid), $past(state) == S_RESP,
    "result beat raised outside the response state")
  `PTT_ASSERT_IMP(a_count_bound, out_valid, int'(live_count) <= FULL_SHOWN,
    "live count above table size")
  `PTT_ASSERT_IMP(a_no_space_full, out_valid && status == ST_NO_SPACE,
    int'(live_count) == FULL_SHOWN, "no-space reported with table not full")

endmodule
